/* rtl/salwc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salwc_pkg
// shared types and constants of the set-associative lru write-back cache
// ----------------------------------------------------------------------------
package salwc_pkg;

	localparam int WaysDef    = 4;
	localparam int MaxSetsDef = 256;
	localparam int KeyBitsDef = 32;
	localparam int KeyW       = 32;
	localparam int CfgW       = 9;
	localparam int SetOutW    = 8;
	localparam int WayOutW    = 2;
	localparam int CntW       = 32;
	localparam logic [CfgW-1:0] NumSetsRst = 9'd256;
	localparam int AddrW      = 1;
	localparam logic [AddrW-1:0] RegNumSets = 1'b0;

	typedef struct packed {
		logic [KeyW-1:0] lookup_key;
		logic            mark_dirty;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [SetOutW-1:0] set_index;
		logic [WayOutW-1:0] way_index;
		logic               writeback;
		logic [KeyW-1:0]    evicted_key;
		logic [CntW-1:0]    hit_total;
		logic [CntW-1:0]    miss_total;
		logic [CntW-1:0]    writeback_total;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_LOOK,
		ST_UPDATE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic rd;
		logic look;
		logic upd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/set_assoc_lru_writeback_cache.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// tag and lru policy engine of a set-associative write-back key cache
// ----------------------------------------------------------------------------
// usage
//   request channel (in_valid/in_ready/in_data) carries one lookup beat:
//   a key and a dirty mark. response channel (out_valid/out_ready/out_data)
//   returns one beat per request: hit flag, set, way, writeback flag and
//   evicted key, plus running hit, miss and writeback totals.
//   the set is key modulo num_sets (0 as 1, at most MAX_SETS), set over apb.
// access sequence
//   the restoring modulo unit retires one key bit per cycle, then the set
//   row is read, the tags are compared and the updated row is written
//   back. one access in flight: a new request is taken in the same cycle
//   the response beat leaves, and not before.
// reset
//   counters clear and all sets read as empty; no clearing pass is run.
// stalls
//   the response is held in its register until out_ready; no new request
//   is taken while it waits.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
	parameter int WAYS     = salwc_pkg::WaysDef,
	parameter int MAX_SETS = salwc_pkg::MaxSetsDef,
	parameter int KEY_BITS = salwc_pkg::KeyBitsDef
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// request channel
	input  wire                          in_valid,
	output logic                         in_ready,
	input  salwc_pkg::req_t              in_data,
	// response channel
	output logic                         out_valid,
	input  wire                          out_ready,
	output salwc_pkg::rsp_t              out_data,
	// register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [salwc_pkg::AddrW+1:0]   paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import salwc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [CfgW-1:0] num_sets_q;

	// register file: a single set count register at offset zero
	wire reg_hit = (paddr[AddrW+1:2] == RegNumSets) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sets_q <= NumSetsRst;
		end else if (psel && penable && pwrite && reg_hit) begin
			num_sets_q <= pwdata[CfgW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_hit ? 32'(num_sets_q) : '0;

	salwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	salwc_dp #(
		.WAYS     (WAYS),
		.MAX_SETS (MAX_SETS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (in_data),
		.num_sets (num_sets_q),
		.rsp      (out_data)
	);

`ifndef NO_ASSERTIONS
	// a response beat never reports a writeback on a hit
	a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.writeback))
		else $error("writeback flagged on a hit");

	// hit and miss totals do not move when a response is accepted together with a new request
	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && in_valid) |=>
		(out_data.hit_total + out_data.miss_total ==
		 $past(out_data.hit_total) + $past(out_data.miss_total)))
		else $error("hit and miss totals moved during a new access");

	// request is never taken while the datapath is busy
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.rd || cmd.look || cmd.upd) |-> !in_ready)
		else $error("request taken mid access");
`endif

endmodule
`default_nettype wire

/* rtl/salwc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salwc_ctrl
// sequencer of one access: reduce, read set, look up, update, present
// ----------------------------------------------------------------------------
module salwc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output salwc_pkg::cmd_t     cmd,
	input  salwc_pkg::sts_t     sts
);
	import salwc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/salwc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// salwc_dp
// datapath: restoring modulo unit, set stores, lru update, counters
// ----------------------------------------------------------------------------
module salwc_dp #(
	parameter int WAYS     = salwc_pkg::WaysDef,
	parameter int MAX_SETS = salwc_pkg::MaxSetsDef,
	parameter int KEY_BITS = salwc_pkg::KeyBitsDef
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  salwc_pkg::cmd_t            cmd,
	output salwc_pkg::sts_t            sts,
	input  salwc_pkg::req_t            req,
	input  wire [salwc_pkg::CfgW-1:0]  num_sets,
	output salwc_pkg::rsp_t            rsp
);
	import salwc_pkg::*;

	localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int DW   = $clog2(MAX_SETS + 1) > CfgW ? $clog2(MAX_SETS + 1) : CfgW;
	localparam int BCW  = $clog2(KEY_BITS + 1);
	localparam int FW   = $clog2(WAYS + 1);
	localparam int ENTW = KEY_BITS + 1;
	localparam int ROWW = WAYS * ENTW;
	localparam int ORDW = WAYS * WW;

	// ---------------- modulo unit, one quotient bit per cycle ----------------
	logic [KEY_BITS-1:0] key_q, shf_q;
	logic                dirty_in_q;
	logic [DW-1:0]       div_q, rem_q;
	logic [BCW-1:0]      bit_q;
	logic [DW:0]         trial;
	logic [DW-1:0]       div_eff;

	always_comb begin
		div_eff = DW'(num_sets);
		if (num_sets == '0) begin
			div_eff = DW'(1);
		end else if (DW'(num_sets) > DW'(MAX_SETS)) begin
			div_eff = DW'(MAX_SETS);
		end
		trial = {rem_q, shf_q[KEY_BITS-1]} - {1'b0, div_q};
	end

	assign sts.div_done = (bit_q == BCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.load) begin
			bit_q <= BCW'(KEY_BITS);
		end else if (cmd.div_step && bit_q != '0) begin
			bit_q <= bit_q - BCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q      <= KEY_BITS'(req.lookup_key);
			shf_q      <= KEY_BITS'(req.lookup_key);
			dirty_in_q <= req.mark_dirty;
			div_q      <= div_eff;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			shf_q <= {shf_q[KEY_BITS-2:0], 1'b0};
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
			end else begin
				rem_q <= {rem_q[DW-2:0], shf_q[KEY_BITS-1]};
			end
		end
	end

	wire [SW-1:0] set_w = rem_q[SW-1:0];

	// ---------------- set stores ----------------
	logic [ROWW-1:0] ent_mem [MAX_SETS];
	logic [ORDW-1:0] ord_mem [MAX_SETS];
	logic [FW-1:0]   fill_mem [MAX_SETS];
	logic [MAX_SETS-1:0] fvalid_q;

	logic [ROWW-1:0] row_q;
	logic [ORDW-1:0] ord_q;
	logic [FW-1:0]   fill_rd_q;
	logic            fvalid_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			row_q     <= ent_mem[set_w];
			ord_q     <= ord_mem[set_w];
			fill_rd_q <= fill_mem[set_w];
		end
	end

	// ---------------- lookup ----------------
	logic [FW-1:0] fill_c;
	logic          found_c;
	logic [WW-1:0] way_c;
	logic [WW-1:0] pos_c;
	logic [WW-1:0] ow;

	assign fill_c = fvalid_rd_q ? fill_rd_q : '0;

	always_comb begin
		found_c = 1'b0;
		way_c   = '0;
		pos_c   = '0;
		for (int p = WAYS - 1; p >= 0; p--) begin
			ow = ord_q[p*WW +: WW];
			if (FW'(p) < fill_c && row_q[32'(ow)*ENTW + 1 +: KEY_BITS] == key_q) begin
				found_c = 1'b1;
				way_c   = ow;
				pos_c   = WW'(p);
			end
		end
	end

	logic          found_s1;
	logic [WW-1:0] way_s1, pos_s1;
	logic [FW-1:0] fill_s1;

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			found_s1 <= found_c;
			way_s1   <= way_c;
			pos_s1   <= pos_c;
			fill_s1  <= fill_c;
		end
	end

	// ---------------- update ----------------
	logic [WW-1:0]   vway, vpos;
	logic [ROWW-1:0] row_n;
	logic [ORDW-1:0] ord_n;
	logic            wb_c;
	logic [KEY_BITS-1:0] ev_c;

	always_comb begin
		wb_c = 1'b0;
		ev_c = '0;
		row_n = row_q;
		if (found_s1) begin
			vway = way_s1;
			vpos = pos_s1;
			row_n[32'(vway)*ENTW] = row_q[32'(vway)*ENTW] | dirty_in_q;
		end else if (fill_s1 < FW'(WAYS)) begin
			vway = fill_s1[WW-1:0];
			vpos = fill_s1[WW-1:0];
			row_n[32'(vway)*ENTW +: ENTW] = {key_q, dirty_in_q};
		end else begin
			vway = ord_q[(WAYS-1)*WW +: WW];
			vpos = WW'(WAYS - 1);
			wb_c = row_q[32'(vway)*ENTW];
			ev_c = wb_c ? row_q[32'(vway)*ENTW + 1 +: KEY_BITS] : '0;
			row_n[32'(vway)*ENTW +: ENTW] = {key_q, dirty_in_q};
		end
		ord_n = ord_q;
		for (int i = 1; i < WAYS; i++) begin
			if (WW'(i) <= vpos) begin
				ord_n[i*WW +: WW] = ord_q[(i-1)*WW +: WW];
			end
		end
		ord_n[0 +: WW] = vway;
	end

	logic [CntW-1:0] hits_q, miss_q, wbs_q;
	logic               hit_q, wb_q;
	logic [SetOutW-1:0] set_q;
	logic [WayOutW-1:0] way_q;
	logic [KeyW-1:0]    evk_q;

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			ent_mem[set_w] <= row_n;
			ord_mem[set_w] <= ord_n;
			if (!found_s1 && fill_s1 < FW'(WAYS)) begin
				fill_mem[set_w] <= fill_s1 + FW'(1);
			end else begin
				fill_mem[set_w] <= fill_s1;
			end
			hit_q <= found_s1;
			set_q <= SetOutW'(rem_q);
			way_q <= WayOutW'(vway);
			wb_q  <= wb_c;
			evk_q <= KeyW'(ev_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q    <= '0;
			fvalid_rd_q <= 1'b0;
			hits_q      <= '0;
			miss_q      <= '0;
			wbs_q       <= '0;
		end else begin
			if (cmd.rd) begin
				fvalid_rd_q <= fvalid_q[set_w];
			end
			if (cmd.upd) begin
				fvalid_q[set_w] <= 1'b1;
				if (found_s1) begin
					hits_q <= hits_q + CntW'(1);
				end else begin
					miss_q <= miss_q + CntW'(1);
				end
				if (wb_c && !found_s1) begin
					wbs_q <= wbs_q + CntW'(1);
				end
			end
		end
	end

	assign rsp.hit             = hit_q;
	assign rsp.set_index       = set_q;
	assign rsp.way_index       = way_q;
	assign rsp.writeback       = wb_q;
	assign rsp.evicted_key     = evk_q;
	assign rsp.hit_total       = hits_q;
	assign rsp.miss_total      = miss_q;
	assign rsp.writeback_total = wbs_q;

endmodule
`default_nettype wire

/* dv/set_assoc_lru_writeback_cache_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_test
// self-checking bench: lookup beats with random gaps and response stalls,
// each response compared against a behavioral lru cache kept alongside
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_test;
	import salwc_pkg::*;

	localparam int NWAYS = 4;
	localparam int NSETS = 256;

	// behavioral cache plus the queue of predicted responses
	class cache_scoreboard;
		logic [KeyW-1:0] tags[NSETS][NWAYS];
		bit              dirty[NSETS][NWAYS];
		int              fill[NSETS];
		int              order[NSETS][NWAYS];
		logic [CntW-1:0] hits, misses, wbacks;
		int              sets_cfg;
		rsp_t            pending[$];
		int              mismatches;

		function void clear();
			foreach (fill[s]) begin
				fill[s] = 0;
				for (int w = 0; w < NWAYS; w++) begin
					tags[s][w] = '0;
					dirty[s][w] = 0;
					order[s][w] = 0;
				end
			end
			hits = 0;
			misses = 0;
			wbacks = 0;
			sets_cfg = NSETS;
			mismatches = 0;
		endfunction

		function void note_lookup(req_t r);
			rsp_t e;
			int eff, s, pos, way;
			bit found;
			eff = (sets_cfg == 0) ? 1 : (sets_cfg > NSETS ? NSETS : sets_cfg);
			s = r.lookup_key % eff;
			found = 0;
			way = 0;
			pos = 0;
			e = '0;
			for (int p = 0; p < fill[s]; p++)
				if (!found && tags[s][order[s][p]] == r.lookup_key) begin
					found = 1;
					pos = p;
					way = order[s][p];
				end
			if (found) begin
				hits++;
				e.hit = 1;
				dirty[s][way] |= r.mark_dirty;
			end else begin
				misses++;
				if (fill[s] < NWAYS) begin
					way = fill[s];
					pos = fill[s];
					fill[s]++;
				end else begin
					way = order[s][NWAYS-1];
					pos = NWAYS - 1;
					if (dirty[s][way]) begin
						e.writeback = 1;
						e.evicted_key = tags[s][way];
						wbacks++;
					end
				end
				tags[s][way] = r.lookup_key;
				dirty[s][way] = r.mark_dirty;
			end
			// promote to most recently used
			for (int i = pos; i > 0; i--) order[s][i] = order[s][i-1];
			order[s][0] = way;
			e.set_index = s[SetOutW-1:0];
			e.way_index = way[WayOutW-1:0];
			e.hit_total = hits;
			e.miss_total = misses;
			e.writeback_total = wbacks;
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit || got.set_index !== e.set_index ||
			    got.way_index !== e.way_index || got.writeback !== e.writeback ||
			    got.evicted_key !== e.evicted_key || got.hit_total !== e.hit_total ||
			    got.miss_total !== e.miss_total ||
			    got.writeback_total !== e.writeback_total) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response mismatch: expected %h actual %h", e, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rsp_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [AddrW+1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	cache_scoreboard sb;
	int send_idle_pct = 0;   // chance of a gap before a beat
	int recv_stall_pct = 0;  // chance of holding out_ready low
	logic [KeyW-1:0] recent_keys[$];

	always #1 clk = ~clk;

	set_assoc_lru_writeback_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// response side: random stalls, check every accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_response(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// apb write: setup then access, only while the block is idle
	task automatic write_num_sets(input int value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {RegNumSets, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.sets_cfg = value & 9'h1ff;
	endtask

	// one lookup beat, held until accepted; valid drops only in a gap
	task automatic send_lookup(input logic [KeyW-1:0] key, input bit dty);
		req_t r;
		r.lookup_key = key;
		r.mark_dirty = dty;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_lookup(r);
	endtask

	// drain all outstanding responses, then settle
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// key picked mostly from recent keys or a small range so sets fill and evict
	function automatic logic [KeyW-1:0] pick_key(int sets);
		int k;
		k = $urandom_range(99);
		if (k < 45 && recent_keys.size() > 0)
			return recent_keys[$urandom_range(recent_keys.size() - 1)];
		if (k < 85) return $urandom_range(sets * 6);
		return $urandom();
	endfunction

	initial begin
		int phase_sets[6] = '{256, 1, 3, 0, 511, 17};
		int idle_cfg[4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{9, 9}};
		logic [KeyW-1:0] key;
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: key extremes, hit with and without dirty, dirty eviction
		send_lookup(32'h0, 1);
		send_lookup(32'hffff_ffff, 0);
		send_lookup(32'h0, 0);
		send_lookup(32'h0000_0100, 1);
		send_lookup(32'h0000_0200, 0);
		send_lookup(32'h0000_0300, 0);
		send_lookup(32'h0000_0400, 0);  // evicts key 0, dirty
		send_lookup(32'h0000_0200, 1);
		send_lookup(32'h0000_0500, 0);  // evicts 0x100, dirty
		send_lookup(32'h0000_0600, 0);  // evicts 0x300, clean
		send_lookup(32'haaaa_aaaa, 1);
		send_lookup(32'h5555_5555, 0);
		drain();

		for (int ph = 0; ph < 24; ph++) begin
			int cfg;
			cfg = phase_sets[ph % 6];
			if (ph > 0) write_num_sets(cfg);
			send_idle_pct = idle_cfg[ph % 4][0];
			recv_stall_pct = idle_cfg[ph % 4][1];
			recent_keys.delete();
			for (int n = 0; n < 68; n++) begin
				int eff;
				eff = (cfg == 0) ? 1 : (cfg > NSETS ? NSETS : cfg);
				key = pick_key(eff);
				if (recent_keys.size() < 24) recent_keys.push_back(key);
				else recent_keys[$urandom_range(23)] = key;
				send_lookup(key, $urandom_range(1));
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
rtl/salwc_pkg.sv
rtl/salwc_ctrl.sv
rtl/salwc_dp.sv
rtl/set_assoc_lru_writeback_cache.sv
dv/set_assoc_lru_writeback_cache_test.sv
